>>> hdl/sit_pkg.sv
package sit_pkg;

	localparam int STATUS_W = 2;
	localparam int POS_W    = 17;

	typedef enum logic [STATUS_W-1:0] {
		ST_HIT      = 2'd0,
		ST_PARALLEL = 2'd1,
		ST_MISS     = 2'd2
	} status_t;

endpackage

>>> hdl/sit_cross.sv
// Stages 1-3: differences, products, perp-dot sums and hit classification.
module sit_cross #(
	parameter int COORD_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic signed [COORD_BITS-1:0] a1x, a1y, a2x, a2y, b1x, b1y, b2x, b2y,
	output logic                         out_valid,
	output sit_pkg::status_t             out_status,
	output logic [2*COORD_BITS+2:0]      out_num,
	output logic [2*COORD_BITS+2:0]      out_den
);
	localparam int DW = COORD_BITS + 1;
	localparam int PW = 2 * DW;
	localparam int FW = 2 * COORD_BITS + 3;

	logic v_s1, v_s2, v_s3;
	logic signed [DW-1:0] ax_s1, ay_s1, bx_s1, by_s1, cx_s1, cy_s1;
	logic signed [PW-1:0] p0_s2, p1_s2, p2_s2, p3_s2, p4_s2, p5_s2;
	logic signed [FW-1:0] f_c, aa_c, bb_c;
	logic                 hit_c;
	sit_pkg::status_t     st_s3;
	logic [FW-1:0]        num_s3, den_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		ax_s1 <= DW'(a2x) - DW'(a1x);
		ay_s1 <= DW'(a2y) - DW'(a1y);
		bx_s1 <= DW'(b2x) - DW'(b1x);
		by_s1 <= DW'(b2y) - DW'(b1y);
		cx_s1 <= DW'(b2x) - DW'(a2x);
		cy_s1 <= DW'(b2y) - DW'(a2y);
		p0_s2 <= ax_s1 * by_s1;
		p1_s2 <= ay_s1 * bx_s1;
		p2_s2 <= ax_s1 * cy_s1;
		p3_s2 <= ay_s1 * cx_s1;
		p4_s2 <= bx_s1 * cy_s1;
		p5_s2 <= by_s1 * cx_s1;
	end

	always_comb begin
		f_c  = FW'(p0_s2) - FW'(p1_s2);
		aa_c = FW'(p2_s2) - FW'(p3_s2);
		bb_c = FW'(p4_s2) - FW'(p5_s2);
		if (f_c < 0)
			hit_c = (aa_c <= 0) && (bb_c <= 0) && (aa_c >= f_c) && (bb_c >= f_c);
		else
			hit_c = (aa_c >= 0) && (bb_c >= 0) && (aa_c <= f_c) && (bb_c <= f_c);
	end

	always_ff @(posedge clk) begin
		if (f_c == '0)
			st_s3 <= sit_pkg::ST_PARALLEL;
		else if (!hit_c)
			st_s3 <= sit_pkg::ST_MISS;
		else
			st_s3 <= sit_pkg::ST_HIT;
		if (f_c < 0) begin
			num_s3 <= aa_c - f_c;
			den_s3 <= -f_c;
		end else begin
			num_s3 <= f_c - aa_c;
			den_s3 <= f_c;
		end
	end

	assign out_valid  = v_s3;
	assign out_status = st_s3;
	assign out_num    = num_s3;
	assign out_den    = den_s3;
endmodule

>>> hdl/sit_divider.sv
// Pipelined restoring divider: one quotient bit per stage.
module sit_divider #(
	parameter int DEN_W         = 35,
	parameter int FRACTION_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  sit_pkg::status_t       in_status,
	input  logic [DEN_W-1:0]       in_num,
	input  logic [DEN_W-1:0]       in_den,
	output logic                   out_valid,
	output sit_pkg::status_t       out_status,
	output logic [FRACTION_BITS:0] out_quot
);
	localparam int NS = FRACTION_BITS + 1;
	localparam int RW = DEN_W + 1;

	logic             v_q  [NS];
	sit_pkg::status_t st_q [NS];
	logic [RW-1:0]    r_q  [NS];
	logic [DEN_W-1:0] d_q  [NS];
	logic [NS-1:0]    q_q  [NS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NS; i++) v_q[i] <= 1'b0;
		end else begin
			v_q[0] <= in_valid;
			for (int i = 1; i < NS; i++) v_q[i] <= v_q[i-1];
		end
	end

	// Stage 0 takes the integer bit; each later stage shifts and subtracts.
	always_ff @(posedge clk) begin
		st_q[0] <= in_status;
		d_q[0]  <= in_den;
		if (in_num >= in_den) begin
			r_q[0] <= RW'(in_num - in_den);
			q_q[0] <= NS'(1);
		end else begin
			r_q[0] <= RW'(in_num);
			q_q[0] <= '0;
		end
		for (int i = 1; i < NS; i++) begin
			st_q[i] <= st_q[i-1];
			d_q[i]  <= d_q[i-1];
			if ({r_q[i-1][RW-2:0], 1'b0} >= RW'(d_q[i-1])) begin
				r_q[i] <= {r_q[i-1][RW-2:0], 1'b0} - RW'(d_q[i-1]);
				q_q[i] <= {q_q[i-1][NS-2:0], 1'b1};
			end else begin
				r_q[i] <= {r_q[i-1][RW-2:0], 1'b0};
				q_q[i] <= {q_q[i-1][NS-2:0], 1'b0};
			end
		end
	end

	assign out_valid  = v_q[NS-1];
	assign out_status = st_q[NS-1];
	assign out_quot   = (st_q[NS-1] == sit_pkg::ST_HIT) ? q_q[NS-1] : '0;
endmodule

>>> hdl/segment_intersection_test_unit.sv
// Channel   | Signals                                   | Handshake
// ----------+-------------------------------------------+---------------------------
// item in   | first_*/second_* start/end x,y            | start while busy low
// result    | status, position                          | done strobe, one cycle
//
// One item per cycle; each result passes through three cross-product stages,
// then one divider stage per quotient bit.
// busy is tied low: the pipeline never stalls as the receiver cannot refuse.
// arst_n clears only the valid bits; data stages are not reset.
module segment_intersection_test_unit #(
	parameter int COORD_BITS    = 16,
	parameter int FRACTION_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [COORD_BITS-1:0]  first_start_x,
	input  logic signed [COORD_BITS-1:0]  first_start_y,
	input  logic signed [COORD_BITS-1:0]  first_end_x,
	input  logic signed [COORD_BITS-1:0]  first_end_y,
	input  logic signed [COORD_BITS-1:0]  second_start_x,
	input  logic signed [COORD_BITS-1:0]  second_start_y,
	input  logic signed [COORD_BITS-1:0]  second_end_x,
	input  logic signed [COORD_BITS-1:0]  second_end_y,
	output logic                          done,
	output logic [sit_pkg::STATUS_W-1:0]  status,
	output logic [sit_pkg::POS_W-1:0]     position
);
	localparam int FW = 2 * COORD_BITS + 3;

	logic             x_valid;
	sit_pkg::status_t x_status, d_status;
	logic [FW-1:0]    x_num, x_den;
	logic [FRACTION_BITS:0] quot;

	assign busy = 1'b0;

	sit_cross #(.COORD_BITS(COORD_BITS)) u_cross (
		.clk(clk), .arst_n(arst_n), .in_valid(start),
		.a1x(first_start_x), .a1y(first_start_y),
		.a2x(first_end_x), .a2y(first_end_y),
		.b1x(second_start_x), .b1y(second_start_y),
		.b2x(second_end_x), .b2y(second_end_y),
		.out_valid(x_valid), .out_status(x_status),
		.out_num(x_num), .out_den(x_den)
	);

	sit_divider #(.DEN_W(FW), .FRACTION_BITS(FRACTION_BITS)) u_div (
		.clk(clk), .arst_n(arst_n), .in_valid(x_valid),
		.in_status(x_status), .in_num(x_num), .in_den(x_den),
		.out_valid(done), .out_status(d_status), .out_quot(quot)
	);

	// Quotient is masked (or zero-extended) to the 17-bit field.
	always_comb begin
		position = '0;
		for (int i = 0; i < sit_pkg::POS_W; i++)
			if (i <= FRACTION_BITS) position[i] = quot[i];
	end

	assign status = d_status;
endmodule

>>> tb/segment_intersection_checker.sv
`timescale 1ns / 100ps
module segment_intersection_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic signed [15:0] first_start_x,
	input  logic signed [15:0] first_start_y,
	input  logic signed [15:0] first_end_x,
	input  logic signed [15:0] first_end_y,
	input  logic signed [15:0] second_start_x,
	input  logic signed [15:0] second_start_y,
	input  logic signed [15:0] second_end_x,
	input  logic signed [15:0] second_end_y,
	input  logic               done,
	input  logic [sit_pkg::STATUS_W-1:0] status,
	input  logic [sit_pkg::POS_W-1:0]    position,
	output int                 failures,
	output int                 pending
);
	typedef struct packed {
		sit_pkg::status_t                 st;
		logic [sit_pkg::POS_W-1:0]        pos;
	} crossing_t;

	crossing_t crossings_due[$];

	// exact long division, Q1.16 truncated
	function automatic logic [sit_pkg::POS_W-1:0] hit_fraction(longint n, longint d);
		longint q;
		longint r;
		q = 0;
		r = n;
		if (r >= d) begin
			q = 1;
			r = r - d;
		end
		for (int i = 0; i < 16; i++) begin
			r = r <<< 1;
			q = q <<< 1;
			if (r >= d) begin
				r = r - d;
				q = q | 1;
			end
		end
		return q[sit_pkg::POS_W-1:0];
	endfunction

	function automatic crossing_t predict_crossing(longint a1x, longint a1y, longint a2x,
			longint a2y, longint b1x, longint b1y, longint b2x, longint b2y);
		crossing_t res;
		longint ax, ay, bx, by, cx, cy, f, aa, bb;
		bit hit;
		ax = a2x - a1x; ay = a2y - a1y;
		bx = b2x - b1x; by = b2y - b1y;
		cx = b2x - a2x; cy = b2y - a2y;
		f  = ax * by - ay * bx;
		aa = ax * cy - ay * cx;
		bb = bx * cy - by * cx;
		res.pos = '0;
		if (f == 0) begin
			res.st = sit_pkg::ST_PARALLEL;
			return res;
		end
		if (f < 0)
			hit = aa <= 0 && bb <= 0 && aa >= f && bb >= f;
		else
			hit = aa >= 0 && bb >= 0 && aa <= f && bb <= f;
		if (!hit) begin
			res.st = sit_pkg::ST_MISS;
			return res;
		end
		res.st = sit_pkg::ST_HIT;
		if (f < 0)
			res.pos = hit_fraction(aa - f, -f);
		else
			res.pos = hit_fraction(f - aa, f);
		return res;
	endfunction

	assign pending = crossings_due.size();

	always @(posedge clk or negedge arst_n) begin
		crossing_t want;
		if (!arst_n) begin
			failures <= 0;
		end else begin
			if (done) begin
				if (crossings_due.size() == 0) begin
					$display("%0t: unexpected result status %0d position %0d", $time,
						status, position);
					failures <= failures + 1;
				end else begin
					want = crossings_due.pop_front();
					if (status !== want.st || position !== want.pos) begin
						$display("%0t: expected status %0d position %0d, got %0d %0d",
							$time, want.st, want.pos, status, position);
						failures <= failures + 1;
					end
				end
			end
			if (start && !busy)
				crossings_due = {crossings_due, predict_crossing(first_start_x,
					first_start_y, first_end_x, first_end_y, second_start_x,
					second_start_y, second_end_x, second_end_y)};
		end
	end
endmodule

>>> tb/segment_intersection_test_unit_test.sv
`timescale 1ns / 100ps
module segment_intersection_test_unit_test;
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy, done;
	logic signed [15:0] c [8] = '{default: '0};
	logic [sit_pkg::STATUS_W-1:0] status;
	logic [sit_pkg::POS_W-1:0] position;
	int failures, pending;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	segment_intersection_test_unit uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.first_start_x(c[0]), .first_start_y(c[1]), .first_end_x(c[2]),
		.first_end_y(c[3]), .second_start_x(c[4]), .second_start_y(c[5]),
		.second_end_x(c[6]), .second_end_y(c[7]),
		.done(done), .status(status), .position(position));

	segment_intersection_checker checker_i (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.first_start_x(c[0]), .first_start_y(c[1]), .first_end_x(c[2]),
		.first_end_y(c[3]), .second_start_x(c[4]), .second_start_y(c[5]),
		.second_end_x(c[6]), .second_end_y(c[7]),
		.done(done), .status(status), .position(position),
		.failures(failures), .pending(pending));

	// Drive one item from the falling edge; hold until accepted, then maybe gap.
	task automatic send_item(input logic signed [15:0] v [8]);
		int gap;
		for (int i = 0; i < 8; i++) c[i] <= v[i];
		start <= 1'b1;
		do @(posedge clk); while (busy);
		@(negedge clk);
		gap = $urandom_range(0, 3);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// Random endpoint: mostly near the origin so crossings are common,
	// sometimes anywhere in range to hit the wide products.
	function automatic logic signed [15:0] coord(int spread);
		if (spread == 0) return 16'($urandom);
		return 16'($signed($urandom_range(0, 2 * spread)) - spread);
	endfunction

	initial begin
		logic signed [15:0] v [8];
		int spread;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// crossing X, parallel, collinear, miss, endpoint touches both ends
		v = '{-10, 0, 10, 0, 0, -10, 0, 10};          send_item(v);
		v = '{0, 0, 10, 0, 0, 5, 10, 5};              send_item(v);
		v = '{0, 0, 10, 0, 20, 0, 30, 0};             send_item(v);
		v = '{0, 0, 1, 1, 5, 0, 6, -3};               send_item(v);
		v = '{0, 0, 10, 0, 10, -5, 10, 5};            send_item(v); // at end of first
		v = '{0, 0, 10, 0, 0, -5, 0, 5};              send_item(v); // at start of first
		v = '{0, 0, 0, 0, 1, 2, 3, 4};                send_item(v); // degenerate
		// extremes of every field
		v = '{-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768}; send_item(v);
		v = '{32767, -32768, -32768, 32767, 32767, 32767, -32768, -32768}; send_item(v);
		v = '{-32768, 0, 32767, 0, 0, -32768, 0, 32767};  send_item(v);
		v = '{-1, -1, -1, -1, -1, -1, -1, -1};            send_item(v);
		v = '{32767, 32767, -32768, -32768, 0, 0, 1, -1}; send_item(v);
		v = '{-32768, -32768, 32767, 32766, 32767, -32768, -32768, 32767}; send_item(v);

		for (int n = 0; n < 2000; n++) begin
			case ($urandom_range(0, 3))
				0: spread = 0;
				1: spread = 8;
				default: spread = 300;
			endcase
			for (int i = 0; i < 8; i++) v[i] = coord(spread);
			if ($urandom_range(0, 9) == 0) begin
				// force parallel: second direction a multiple of the first
				v[6] = 16'(v[4] + 2 * (v[2] - v[0]));
				v[7] = 16'(v[5] + 2 * (v[3] - v[1]));
				if (spread == 0) begin
					v[6] = v[4]; v[7] = v[5];
				end
			end
			if (spread != 0 && $urandom_range(0, 9) == 0) begin
				// share an endpoint
				v[6] = v[2]; v[7] = v[3];
			end
			send_item(v);
		end
		start <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (25) @(posedge clk);
		if (failures == 0)
			$display("[segment_intersection_test_unit] OK");
		else
			$display("[segment_intersection_test_unit] ERROR");
		$finish;
	end

	initial begin
		#1000000;
		$display("[segment_intersection_test_unit] ERROR");
		$finish;
	end
endmodule
